// ===== rtl/pfsf_pkg.sv =====
// Shared types and constants for the stream printf formatter.
// Used by the front parser, the back formatter and the top level.
package pfsf_pkg;

  localparam int unsigned MaxArgW = 64;

  localparam logic [7:0] ChPct   = 8'h25;  // '%'
  localparam logic [7:0] ChH     = 8'h68;  // 'h'
  localparam logic [7:0] ChL     = 8'h6c;  // 'l'
  localparam logic [7:0] ChC     = 8'h63;  // 'c'
  localparam logic [7:0] ChD     = 8'h64;  // 'd'
  localparam logic [7:0] ChI     = 8'h69;  // 'i'
  localparam logic [7:0] ChU     = 8'h75;  // 'u'
  localparam logic [7:0] ChO     = 8'h6f;  // 'o'
  localparam logic [7:0] ChX     = 8'h78;  // 'x'
  localparam logic [7:0] ChXUp   = 8'h58;  // 'X'
  localparam logic [7:0] ChP     = 8'h50;  // 'P'
  localparam logic [7:0] ChMinus = 8'h2d;  // '-'
  localparam logic [7:0] ChNul   = 8'h00;

  typedef enum logic [1:0] {
    CK_CHAR,
    CK_DEC,
    CK_HEX,
    CK_OCT
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e            kind;
    logic [7:0]           ch;    // character for CK_CHAR
    logic                 neg;   // print a leading minus
    logic                 wide;  // ll length: full argument width
    logic [MaxArgW-1:0]   mag;   // magnitude, already masked
  } cmd_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] r;
    if (d < 4'd10) begin
      r = 8'h30 + {4'h0, d};
    end else begin
      r = 8'h57 + {4'h0, d};
    end
    return r;
  endfunction

endpackage

// ===== rtl/pfsf_front.sv =====
// Front parser: tracks the % / length prefix state and turns each plain text byte and
// each known conversion into a queued command. Depends on pfsf_pkg.
module pfsf_front #(
  parameter int unsigned ARG_WIDTH = 64
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    accept_i,
  input  logic [7:0]              char_i,
  input  logic [63:0]             arg_i,
  output logic                    push_o,
  output pfsf_pkg::cmd_t          cmd_o
);
  import pfsf_pkg::*;

  typedef enum logic [1:0] {PH_NORMAL, PH_PCT, PH_H, PH_L} phase_e;
  typedef enum logic [2:0] {LM_DEF, LM_H, LM_HH, LM_L, LM_LL} len_e;

  localparam logic [MaxArgW-1:0] WideMask = {MaxArgW{1'b1}} >> (MaxArgW - ARG_WIDTH);
  localparam logic [MaxArgW-1:0] NarrowMask = {32'h0, 32'hffff_ffff};

  phase_e phase_q, phase_d;
  len_e   len_q, len_d;
  logic   conv;
  logic   wide;
  logic   sgn;
  logic [MaxArgW-1:0] mask;
  logic [MaxArgW-1:0] masked;
  logic   neg_bit;
  logic   push;

  always_comb begin
    phase_d = phase_q;
    len_d   = len_q;
    conv    = 1'b0;
    push    = 1'b0;
    sgn     = 1'b0;
    cmd_o.kind = CK_CHAR;
    cmd_o.ch   = char_i;
    wide    = (len_q == LM_LL);
    mask    = wide ? WideMask : NarrowMask;
    masked  = arg_i & mask;
    neg_bit = wide ? arg_i[ARG_WIDTH-1] : arg_i[31];

    if (char_i == ChNul) begin
      phase_d = PH_NORMAL;
      len_d   = LM_DEF;
    end else begin
      case (phase_q)
        PH_NORMAL: begin
          if (char_i == ChPct) begin
            phase_d = PH_PCT;
          end else begin
            push = 1'b1;
          end
        end
        PH_PCT: begin
          if (len_q == LM_HH || len_q == LM_LL) begin
            conv = 1'b1;
          end else if (char_i == ChH) begin
            len_d   = LM_H;
            phase_d = PH_H;
          end else if (char_i == ChL) begin
            len_d   = LM_L;
            phase_d = PH_L;
          end else begin
            conv = 1'b1;
          end
        end
        PH_H: begin
          if (char_i == ChH) begin
            len_d   = LM_HH;
            phase_d = PH_PCT;
          end else begin
            conv = 1'b1;
          end
        end
        default: begin
          if (char_i == ChL) begin
            len_d   = LM_LL;
            phase_d = PH_PCT;
          end else begin
            conv = 1'b1;
          end
        end
      endcase
    end

    if (conv) begin
      phase_d = PH_NORMAL;
      len_d   = LM_DEF;
      case (char_i) inside
        ChC: begin
          push     = 1'b1;
          cmd_o.ch = arg_i[7:0];
        end
        ChPct: begin
          push = 1'b1;
        end
        ChD, ChI: begin
          push       = 1'b1;
          sgn        = 1'b1;
          cmd_o.kind = CK_DEC;
        end
        ChU: begin
          push       = 1'b1;
          cmd_o.kind = CK_DEC;
        end
        ChX, ChXUp, ChP: begin
          push       = 1'b1;
          cmd_o.kind = CK_HEX;
        end
        ChO: begin
          push       = 1'b1;
          cmd_o.kind = CK_OCT;
        end
        default: begin
          push = 1'b0;  // unknown conversion emits nothing
        end
      endcase
    end

    cmd_o.neg  = sgn & neg_bit;
    cmd_o.wide = wide;
    cmd_o.mag  = (sgn & neg_bit) ? ((~masked + MaxArgW'(1)) & mask) : masked;
  end

  assign push_o = accept_i & push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_NORMAL;
      len_q   <= LM_DEF;
    end else if (accept_i) begin
      phase_q <= phase_d;
      len_q   <= len_d;
    end
  end

endmodule

// ===== rtl/pfsf_queue.sv =====
// Two-entry command queue between the front parser and the back formatter.
// Depends on nothing but its width parameter.
module pfsf_queue #(
  parameter int unsigned W = 76
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  input  logic         pop_i,
  output logic [W-1:0] data_o,
  output logic         full_o,
  output logic         empty_o
);
  logic [W-1:0] mem_q [2];
  logic         wr_q, rd_q;
  logic [1:0]   cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop_i) begin
        rd_q <= ~rd_q;
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ===== rtl/pfsf_back.sv =====
// Back formatter: shift-add-3 BCD for decimal, leading zero skip, then one character
// per cycle unless output stalls, into the output register. Depends on pfsf_pkg.
module pfsf_back #(
  parameter int unsigned ARG_WIDTH = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            empty_i,
  input  pfsf_pkg::cmd_t  cmd_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [7:0]      out_char_o,
  output logic            out_last_o
);
  import pfsf_pkg::*;

  localparam int unsigned NDig = (ARG_WIDTH + 2) / 3;  // octal digit count bounds all radixes
  localparam int unsigned BufW = NDig * 4;
  localparam int unsigned CntW = $clog2(ARG_WIDTH + 1);

  typedef enum logic [2:0] {ST_IDLE, ST_CHAR, ST_DAB, ST_SKIP, ST_SIGN, ST_DIG} state_e;

  state_e              state_q;
  logic [BufW-1:0]     buf_q;
  logic [ARG_WIDTH-1:0] bin_q;
  logic [CntW-1:0]     cnt_q;
  logic                neg_q;
  logic [7:0]          ch_q;
  logic                ovalid_q;
  logic [7:0]          ochar_q;
  logic                olast_q;

  logic                adv;
  logic                emit;
  logic [BufW-1:0]     adj;
  logic [BufW-1:0]     hex_load;
  logic [BufW-1:0]     oct_load;
  logic [BufW-1:0]     magp;
  logic [3:0]          top;

  assign adv   = !ovalid_q || out_ready_i;
  assign emit  = adv && (state_q inside {ST_CHAR, ST_SIGN, ST_DIG});
  assign pop_o = (state_q == ST_IDLE) && !empty_i;
  assign top   = buf_q[BufW-1 -: 4];

  always_comb begin
    magp     = BufW'(cmd_i.mag[ARG_WIDTH-1:0]);
    hex_load = magp;
    oct_load = '0;
    for (int k = 0; k < NDig; k++) begin
      oct_load[4*k +: 4] = {1'b0, magp[3*k +: 3]};
      adj[4*k +: 4] = (buf_q[4*k +: 4] >= 4'd5) ? buf_q[4*k +: 4] + 4'd3 : buf_q[4*k +: 4];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ovalid_q <= 1'b0;
      cnt_q    <= '0;
      buf_q    <= '0;
      bin_q    <= '0;
      neg_q    <= 1'b0;
      ch_q     <= '0;
      ochar_q  <= '0;
      olast_q  <= 1'b0;
    end else begin
      // drained and nothing new loaded this cycle
      if (ovalid_q && out_ready_i && !emit) begin
        ovalid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (!empty_i) begin
            neg_q <= cmd_i.neg;
            ch_q  <= cmd_i.ch;
            case (cmd_i.kind)
              CK_CHAR: state_q <= ST_CHAR;
              CK_DEC: begin
                buf_q   <= '0;
                bin_q   <= cmd_i.wide ? cmd_i.mag[ARG_WIDTH-1:0]
                                      : cmd_i.mag[ARG_WIDTH-1:0] << (ARG_WIDTH - 32);
                cnt_q   <= cmd_i.wide ? CntW'(ARG_WIDTH) : CntW'(32);
                state_q <= ST_DAB;
              end
              CK_HEX: begin
                buf_q   <= hex_load;
                cnt_q   <= CntW'(NDig);
                state_q <= ST_SKIP;
              end
              default: begin
                buf_q   <= oct_load;
                cnt_q   <= CntW'(NDig);
                state_q <= ST_SKIP;
              end
            endcase
          end
        end
        ST_CHAR: begin
          if (adv) begin
            ovalid_q <= 1'b1;
            ochar_q  <= ch_q;
            olast_q  <= 1'b1;
            state_q  <= ST_IDLE;
          end
        end
        ST_DAB: begin
          buf_q <= {adj[BufW-2:0], bin_q[ARG_WIDTH-1]};
          bin_q <= bin_q << 1;
          if (cnt_q == CntW'(1)) begin
            cnt_q   <= CntW'(NDig);
            state_q <= ST_SKIP;
          end else begin
            cnt_q <= cnt_q - CntW'(1);
          end
        end
        ST_SKIP: begin
          if (top == 4'd0 && cnt_q > CntW'(1)) begin
            buf_q <= buf_q << 4;
            cnt_q <= cnt_q - CntW'(1);
          end else begin
            state_q <= neg_q ? ST_SIGN : ST_DIG;
          end
        end
        ST_SIGN: begin
          if (adv) begin
            ovalid_q <= 1'b1;
            ochar_q  <= ChMinus;
            olast_q  <= 1'b0;
            state_q  <= ST_DIG;
          end
        end
        ST_DIG: begin
          if (adv) begin
            ovalid_q <= 1'b1;
            ochar_q  <= digit_char(top);
            olast_q  <= (cnt_q == CntW'(1));
            buf_q    <= buf_q << 4;
            cnt_q    <= cnt_q - CntW'(1);
            if (cnt_q == CntW'(1)) begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = ovalid_q;
  assign out_char_o  = ochar_q;
  assign out_last_o  = olast_q;

endmodule

// ===== rtl/printf_format_stream_formatter.sv =====
// Stream printf formatter, integer conversions only (%c %% %d %i %u %x %X %P %o, h/hh/l/ll).
// A plain character or %c goes through the queue, ST_CHAR and the output register to m_axis.
// Decimal: a dequeue, a shift-add-3 pass over 32 bits (or ARG_WIDTH for ll), a skip of up
// to 21 leading zero digits, then one character per cycle while m_axis is not stalled
// (sign included); hex/octal skip the BCD pass. Output stalls hold the character stream.
// The back formatter handles one command at a time; its digit pass sets throughput.
// Reset (rst_ni low, async) clears parse state, the queue and the output register.
module printf_format_stream_formatter #(
  parameter int unsigned ARG_WIDTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [71:0] s_axis_tdata_i,   // [7:0] format_char, [71:8] arg_value
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // [7:0] out_char
  output logic        m_axis_tlast_o    // last_of_item
);
  import pfsf_pkg::*;

  localparam int unsigned CmdW = $bits(cmd_t);

  logic            in_xfer;
  logic            push;
  logic            pop;
  logic            q_full;
  logic            q_empty;
  cmd_t            cmd_in;
  logic [CmdW-1:0] cmd_out_bits;
  cmd_t            cmd_out;

  // Front takes a byte whenever the queue has room; bytes that emit nothing
  // (prefix characters, unknown conversions, NUL) only update parse state.
  assign s_axis_tready_o = !q_full;
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;

  pfsf_front #(.ARG_WIDTH(ARG_WIDTH)) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_xfer),
    .char_i   (s_axis_tdata_i[7:0]),
    .arg_i    (s_axis_tdata_i[71:8]),
    .push_o   (push),
    .cmd_o    (cmd_in)
  );

  // Short decoupling queue: parser keeps taking text while digits are produced.
  pfsf_queue #(.W(CmdW)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cmd_in),
    .pop_i   (pop),
    .data_o  (cmd_out_bits),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  assign cmd_out = cmd_t'(cmd_out_bits);

  // Back end owns the output register; each transfer is one character.
  pfsf_back #(.ARG_WIDTH(ARG_WIDTH)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (q_empty),
    .cmd_i       (cmd_out),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_char_o  (m_axis_tdata_o),
    .out_last_o  (m_axis_tlast_o)
  );

  // Queue never overflows: a push only follows an accepted byte, which needs room.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(push && q_full))
    else $error("command queue overflow");

  // Back end never pops an empty queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(pop && q_empty))
    else $error("command queue underflow");

  // A push into an empty queue makes it non-empty on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) (push && q_empty) |=> !q_empty)
    else $error("queued command lost");

endmodule
